/* rtl/ptt_pkg.sv */
// ptt_pkg: shared types, codes and constants of the periodic timer table
// no dependencies
`timescale 1ns / 1ps
package ptt_pkg;

  localparam int NUM_TIMERS_DEF  = 16;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int TIME_W          = 32;

  typedef enum logic [1:0] {
    FN_REGISTER   = 2'd0,
    FN_UNREGISTER = 2'd1,
    FN_TICK       = 2'd2,
    FN_READ_TIME  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    K_REGISTERED   = 3'd0,
    K_NONE_FREE    = 3'd1,
    K_UNREGISTERED = 3'd2,
    K_REFUSED      = 3'd3,
    K_FIRED        = 3'd4,
    K_NO_FIRE      = 3'd5,
    K_TIME         = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] interval_ticks;
    logic signed [15:0] repeat_count;
    logic [3:0]  entry_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [3:0]  timer_index;
    logic [31:0] system_time;
    logic        last;
  } out_item_t;

  // request to the modulo unit and its answer
  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } mod_sts_t;

endpackage

/* rtl/ptt_mod_unit.sv */
// ptt_mod_unit: restoring divider that tells whether a divisor divides the counter
// depends on ptt_pkg
`timescale 1ns / 1ps
module ptt_mod_unit import ptt_pkg::*; #(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mod_ctl_t               ctl,
  input  logic [TIME_W-1:0]      dividend,
  input  logic [PERIOD_BITS-1:0] divisor,
  output mod_sts_t               sts
);

  localparam int CNT_W = $clog2(TIME_W + 1);

  logic [TIME_W-1:0]      quo_r, quo_nxt;
  logic [PERIOD_BITS:0]   rem_r, rem_nxt;
  logic [PERIOD_BITS-1:0] div_r, div_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [PERIOD_BITS:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[PERIOD_BITS-1:0], quo_r[TIME_W-1]};
    if (ctl.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = CNT_W'(TIME_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit a cycle
      quo_nxt = {quo_r[TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) rem_nxt = trial - {1'b0, div_r};
      else rem_nxt = trial;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.zero = (rem_r == '0);

endmodule

/* rtl/periodic_timer_table_core.sv */
// periodic_timer_table_core: top level, sequencer, entry memory and free-id fifo
// depends on ptt_pkg and ptt_mod_unit
`timescale 1ns / 1ps
// One item at a time. After reset a pass loads the free-id fifo with ids 0 upwards,
// and no item is taken until it ends. A register item passes a decode state and a
// write state; unregister and read-time items end at decode. A tick walks every
// entry in id order. An inactive entry takes a single walk state. An active entry
// costs a memory read and a modulo in the shared divider, and an emit step if it
// fires. A tick can also be held by output stalls. Each fire result is held back
// until the walk finds the next fire or ends, so that the final one can carry last.
// Period and repeat counts live in one single-port memory with registered read;
// the free-id fifo is a second memory. Results leave through an output register,
// so a waiting result holds the sequencer only until it is taken.
module periodic_timer_table_core import ptt_pkg::*; #(
  parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int ENT_W = PERIOD_BITS + 16;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_RDW   = 9'b000000100,
    S_WALK  = 9'b000001000,
    S_RDE   = 9'b000010000,
    S_MOD   = 9'b000100000,
    S_EMIT  = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_INIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ENT_W-1:0] ent_mem [NUM_TIMERS];
  logic [IDX_W-1:0] fifo_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] active_r, active_nxt;

  logic [ENT_W-1:0] ent_q;
  logic [IDX_W-1:0] fifo_q;
  logic             ent_we;
  logic [IDX_W-1:0] ent_addr;
  logic [ENT_W-1:0] ent_wd;
  logic             fifo_we;
  logic [IDX_W-1:0] fifo_waddr;
  logic [IDX_W-1:0] fifo_wd;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  in_item_t         item_r, item_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic             fired_r, fired_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        od_r, od_nxt;

  mod_ctl_t mctl;
  mod_sts_t msts;

  logic [PERIOD_BITS-1:0] per_in;
  logic [15:0]            rep_q;
  logic                   out_free;
  logic                   last_idx;
  logic [CNT_W:0]         tail_sum;
  logic [IDX_W-1:0]       tail;

  assign out_free = !ov_r || out_ready;
  assign rep_q    = ent_q[15:0];
  assign last_idx = (32'(idx_r) == NUM_TIMERS - 1);
  assign tail_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
  assign tail     = (32'(tail_sum) >= NUM_TIMERS) ?
                    IDX_W'(32'(tail_sum) - NUM_TIMERS) : IDX_W'(tail_sum);
  assign per_in   = (item_r.interval_ticks[PERIOD_BITS-1:0] == '0) ?
                    PERIOD_BITS'(1) : item_r.interval_ticks[PERIOD_BITS-1:0];

  ptt_mod_unit #(.PERIOD_BITS(PERIOD_BITS)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .dividend(time_r),
    .divisor (ent_q[ENT_W-1:16]),
    .sts     (msts)
  );

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_addr] <= ent_wd;
    ent_q <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wd;
    fifo_q <= fifo_mem[head_r];
  end

  task automatic put(input kind_t k, input logic [IDX_W-1:0] ix, input logic lst);
    ov_nxt             = 1'b1;
    od_nxt.result_kind = k;
    od_nxt.timer_index = 4'(ix);
    od_nxt.system_time = time_nxt;
    od_nxt.last        = lst;
  endtask

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    time_nxt   = time_r;
    item_nxt   = item_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    fired_nxt  = fired_r;
    ov_nxt     = ov_r && !out_ready;
    od_nxt     = od_r;
    ent_we     = 1'b0;
    ent_addr   = idx_r;
    ent_wd     = '0;
    fifo_we    = 1'b0;
    fifo_waddr = tail;
    fifo_wd    = idx_r;
    mctl.start = 1'b0;
    in_ready   = (state_r == S_IDLE);
    unique case (state_r)
      S_INIT: begin
        // load the fifo with ids in order
        fifo_we    = 1'b1;
        fifo_waddr = idx_r;
        if (last_idx) state_nxt = S_IDLE;
        else idx_nxt = idx_r + 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          idx_nxt   = IDX_W'(in_data.entry_id);
          fired_nxt = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (out_free) begin
          unique case (func_t'(item_r.func))
            FN_REGISTER: begin
              if (count_r == '0) begin
                put(K_NONE_FREE, '0, 1'b1);
                state_nxt = S_IDLE;
              end else state_nxt = S_RDW;
            end
            FN_UNREGISTER: begin
              if (32'(item_r.entry_id) >= NUM_TIMERS || !active_r[idx_r]) begin
                ov_nxt             = 1'b1;
                od_nxt.result_kind = K_REFUSED;
                od_nxt.timer_index = item_r.entry_id;
                od_nxt.system_time = time_r;
                od_nxt.last        = 1'b1;
              end else begin
                active_nxt[idx_r] = 1'b0;
                fifo_we   = 1'b1;
                count_nxt = count_r + 1'b1;
                put(K_UNREGISTERED, idx_r, 1'b1);
              end
              state_nxt = S_IDLE;
            end
            FN_TICK: begin
              time_nxt  = time_r + 1'b1;
              idx_nxt   = '0;
              state_nxt = S_WALK;
            end
            default: begin
              put(K_TIME, '0, 1'b1);
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RDW: begin
        // fifo_q holds the oldest free id
        ent_addr = fifo_q;
        ent_we   = 1'b1;
        ent_wd   = {per_in, item_r.repeat_count};
        active_nxt[fifo_q] = 1'b1;
        head_nxt  = (32'(head_r) == NUM_TIMERS - 1) ? '0 : head_r + 1'b1;
        count_nxt = count_r - 1'b1;
        put(K_REGISTERED, fifo_q, 1'b1);
        state_nxt = S_IDLE;
      end
      S_WALK: begin
        if (active_r[idx_r]) state_nxt = S_RDE;
        else if (last_idx) state_nxt = S_DONE;
        else idx_nxt = idx_r + 1'b1;
      end
      S_RDE: begin
        mctl.start = 1'b1;
        state_nxt  = S_MOD;
      end
      S_MOD: begin
        if (msts.done) begin
          if (msts.zero) state_nxt = S_EMIT;
          else if (last_idx) state_nxt = S_DONE;
          else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_WALK;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          // the previous fire is not the final one
          if (fired_r) put(K_FIRED, pidx_r, 1'b0);
          pidx_nxt  = idx_r;
          fired_nxt = 1'b1;
          if (!rep_q[15]) begin
            if (rep_q != '0) begin
              ent_we = 1'b1;
              ent_wd = {ent_q[ENT_W-1:16], rep_q - 16'd1};
            end else begin
              active_nxt[idx_r] = 1'b0;
              fifo_we   = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          if (last_idx) state_nxt = S_DONE;
          else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_WALK;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (fired_r) put(K_FIRED, pidx_r, 1'b1);
          else put(K_NO_FIRE, '0, 1'b1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      active_r <= '0;
      head_r   <= '0;
      count_r  <= CNT_W'(NUM_TIMERS);
      time_r   <= '0;
      ov_r     <= 1'b0;
      fired_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      time_r   <= time_nxt;
      ov_r     <= ov_nxt;
      fired_r  <= fired_nxt;
      idx_r    <= idx_nxt;
    end
    item_r <= item_nxt;
    pidx_r <= pidx_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= NUM_TIMERS)
    else $error("free count above table size");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("item accepted while busy");
  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    msts.done |-> state_r == S_MOD)
    else $error("divider finished outside walk");

endmodule

/* tb/ptt_checker.sv */
// ptt_checker: watches both channels of the periodic timer table, predicts each result
// and compares it; depends on ptt_pkg
`timescale 1ns / 1ps
module ptt_checker import ptt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int NT = 16;

  logic [31:0] ticks;
  logic        active  [NT];
  logic [15:0] period  [NT];
  logic [15:0] reps    [NT];
  logic [3:0]  free_ids[NT];
  int          head;
  int          free_cnt;
  out_item_t   due_q[$];

  function automatic out_item_t mk(kind_t k, logic [3:0] idx);
    out_item_t r;
    r.result_kind = k;
    r.timer_index = idx;
    r.system_time = ticks;
    r.last        = 1'b0;
    return r;
  endfunction

  task automatic release_entry(int id);
    active[id] = 1'b0;
    if (free_cnt < NT) begin
      free_ids[(head + free_cnt) % NT] = id[3:0];
      free_cnt++;
    end
  endtask

  task automatic predict(in_item_t it);
    out_item_t res[$];
    int id;
    logic [15:0] per;
    case (func_t'(it.func))
      FN_REGISTER: begin
        if (free_cnt == 0) begin
          res.push_back(mk(K_NONE_FREE, 4'd0));
        end else begin
          id = free_ids[head];
          head = (head + 1) % NT;
          free_cnt--;
          period[id] = (it.interval_ticks == 16'd0) ? 16'd1 : it.interval_ticks;
          reps[id] = it.repeat_count;
          active[id] = 1'b1;
          res.push_back(mk(K_REGISTERED, id[3:0]));
        end
      end
      FN_UNREGISTER: begin
        if (!active[it.entry_id]) begin
          res.push_back(mk(K_REFUSED, it.entry_id));
        end else begin
          release_entry(it.entry_id);
          res.push_back(mk(K_UNREGISTERED, it.entry_id));
        end
      end
      FN_TICK: begin
        ticks = ticks + 32'd1;
        for (int i = 0; i < NT; i++) begin
          if (active[i]) begin
            per = (period[i] == 16'd0) ? 16'd1 : period[i];
            if (ticks % {16'd0, per} == 32'd0) begin
              res.push_back(mk(K_FIRED, i[3:0]));
              if (!reps[i][15]) begin
                if (reps[i] != 16'd0) reps[i] = reps[i] - 16'd1;
                else release_entry(i);
              end
            end
          end
        end
        if (res.size() == 0) res.push_back(mk(K_NO_FIRE, 4'd0));
      end
      default: res.push_back(mk(K_TIME, 4'd0));
    endcase
    res[res.size() - 1].last = 1'b1;
    foreach (res[j]) due_q.push_back(res[j]);
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      ticks = '0;
      head = 0;
      free_cnt = NT;
      for (int i = 0; i < NT; i++) begin
        active[i] = 1'b0;
        period[i] = '0;
        reps[i] = '0;
        free_ids[i] = i[3:0];
      end
      due_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) predict(in_data);
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected item %p", $time, out_data);
          fail_count++;
        end else begin
          exp_r = due_q.pop_front();
          if (out_data.result_kind !== exp_r.result_kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time,
                     exp_r.result_kind, out_data.result_kind);
            fail_count++;
          end
          if (out_data.timer_index !== exp_r.timer_index) begin
            $display("%0t: timer_index expected %0d actual %0d", $time,
                     exp_r.timer_index, out_data.timer_index);
            fail_count++;
          end
          if (out_data.system_time !== exp_r.system_time) begin
            $display("%0t: system_time expected %0d actual %0d", $time,
                     exp_r.system_time, out_data.system_time);
            fail_count++;
          end
          if (out_data.last !== exp_r.last) begin
            $display("%0t: last expected %0d actual %0d", $time,
                     exp_r.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
    pending = due_q.size();
  end

endmodule

/* tb/tb_periodic_timer_table_core.sv */
// tb_periodic_timer_table_core: drives directed and random items into the timer table
// under varied idling; depends on ptt_pkg, periodic_timer_table_core and ptt_checker
`timescale 1ns / 1ps
module tb_periodic_timer_table_core;
  import ptt_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        idle_pct;
  int        stall_pct;

  periodic_timer_table_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ptt_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t item(func_t f, logic [15:0] iv, logic [15:0] rc,
                                    logic [3:0] id);
    in_item_t it;
    it.func = f;
    it.interval_ticks = iv;
    it.repeat_count = rc;
    it.entry_id = id;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int r;
    it = in_item_t'({$urandom, $urandom});
    r = $urandom_range(99);
    if (r < 30) it.func = FN_REGISTER;
    else if (r < 50) it.func = FN_UNREGISTER;
    else if (r < 90) it.func = FN_TICK;
    else it.func = FN_READ_TIME;
    r = $urandom_range(99);
    if (r < 80) it.interval_ticks = 16'($urandom_range(6, 1));
    else if (r < 90) it.interval_ticks = '0;
    r = $urandom_range(99);
    if (r < 30) it.repeat_count = -16'sd1;
    else if (r < 70) it.repeat_count = 16'($urandom_range(3));
    else if (r < 80) it.repeat_count = 16'sd32767;
    return it;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero period, extremes, negative repeats, full table, bad unregister
    send(item(FN_READ_TIME, 16'hffff, 16'hffff, 4'hf));
    send(item(FN_TICK, 16'd0, 16'd0, 4'd0));
    send(item(FN_REGISTER, 16'd0, 16'd0, 4'd0));
    send(item(FN_TICK, 16'd0, 16'd0, 4'd0));
    send(item(FN_UNREGISTER, 16'd0, 16'd0, 4'd0));
    send(item(FN_REGISTER, 16'hffff, 16'h7fff, 4'd0));
    send(item(FN_REGISTER, 16'd1, 16'hffff, 4'd0));
    send(item(FN_REGISTER, 16'd2, 16'h8000, 4'd0));
    send(item(FN_REGISTER, 16'd3, 16'd1, 4'd0));
    for (int i = 0; i < 13; i++) send(item(FN_REGISTER, 16'd1, 16'd2, 4'd0));
    send(item(FN_TICK, 16'd0, 16'd0, 4'd0));
    send(item(FN_TICK, 16'd0, 16'd0, 4'd0));
    send(item(FN_UNREGISTER, 16'd0, 16'd0, 4'd1));
    send(item(FN_UNREGISTER, 16'd0, 16'd0, 4'd15));
    send(item(FN_REGISTER, 16'd4, 16'd0, 4'd0));
    drain();

    for (int i = 0; i < 350; i++) begin
      case (i * 4 / 350)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 70; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 70; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      if (i == 150) drain();
      send(rand_item());
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
